// ----- rtl/drs_pkg.sv -----
// Shared types and constants of the disk request scheduler.
package drs_pkg;

   localparam int CYL_W         = 14;
   localparam int MOVE_W        = 32;
   localparam int DIST_W        = 16;
   localparam int MODE_W        = 2;
   localparam int SLOTS_REG_W   = 5;
   localparam int CSR_INDEX_W   = 2;
   localparam int CSR_DATA_W    = 14;
   localparam int DEFAULT_SLOTS = 16;

   localparam logic [CYL_W-1:0]       MAX_CYL_RESET   = CYL_W'(9999);
   localparam logic [SLOTS_REG_W-1:0] SLOTS_REG_RESET = SLOTS_REG_W'(16);

   localparam logic [MODE_W-1:0] MODE_FCFS  = 2'd0;
   localparam logic [MODE_W-1:0] MODE_SSTF  = 2'd1;
   localparam logic [MODE_W-1:0] MODE_CSCAN = 2'd2;

   localparam logic CMD_REQUEST = 1'b0;
   localparam logic CMD_DRAIN   = 1'b1;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_MODE      = 2'd0,
      CSR_START_POS = 2'd1,
      CSR_MAX_CYL   = 2'd2,
      CSR_SLOTS     = 2'd3
   } csr_index_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_REDUCE,
      ST_SCAN,
      ST_MOVE,
      ST_SUM
   } state_type;

   // Running best candidate handed from cell to cell.
   typedef struct packed {
      logic             found;
      logic             up;
      logic [CYL_W-1:0] key;
      logic [CYL_W-1:0] cyl;
      logic [1:0]       many;
   } drs_rec_type;

   // Slot write broadcast to the row.
   typedef struct packed {
      logic             en;
      logic             valid;
      logic [CYL_W-1:0] cyl;
   } drs_write_type;

   // Search policy broadcast to the row.
   typedef struct packed {
      logic             sstf;
      logic             cscan;
      logic [CYL_W-1:0] head;
   } drs_scan_type;

endpackage

// ----- rtl/disk_request_scheduler_top.sv -----
// Disk request scheduler: slot row, service sequencer and register file.
//
// A request that fills the buffer is stored in the next free slot and gives no
// response. A service (a request once the buffer is full, or a drain) walks
// the search record along the row of slot cells in use, one cell per cycle;
// then the move state settles the pick and the seek distance and the sum state
// adds it to the saturating total. If the slot count was lowered below the ring
// pointer, the pointer is first brought into range by repeated subtraction.
// busy is high during a service and start is taken only while it is low. The
// response is shown for exactly one cycle with rsp_valid; the receiver cannot
// stall it. Registers are written through the csr_ port while busy is low;
// writing start_position also moves the head. No clearing pass follows reset.
module disk_request_scheduler_top #(
   parameter int SLOTS = drs_pkg::DEFAULT_SLOTS
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   output logic                                 busy,
   input  logic                                 req_command,
   input  logic [drs_pkg::CYL_W-1:0]            req_cylinder,
   output logic                                 rsp_valid,
   output logic [drs_pkg::CYL_W-1:0]            rsp_served_cylinder,
   output logic [drs_pkg::MOVE_W-1:0]           rsp_total_movement,
   output logic                                 rsp_wrapped,
   output logic                                 rsp_last,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [drs_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  logic [drs_pkg::CSR_DATA_W-1:0]       csr_data
);
   import drs_pkg::*;

   localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int CNT_W = $clog2(SLOTS + 1);

   state_type              state_ff, state_in;
   logic [MODE_W-1:0]      mode_ff, mode_in;
   logic [CYL_W-1:0]       max_ff, max_in;
   logic [SLOTS_REG_W-1:0] slots_ff, slots_in;
   logic [CYL_W-1:0]       head_ff, head_in;
   logic [CNT_W-1:0]       fill_ff, fill_in;
   logic [IDX_W-1:0]       ptr_ff, ptr_in;
   logic [IDX_W-1:0]       ptr_work_ff, ptr_work_in;
   logic [CNT_W-1:0]       scan_cnt_ff, scan_cnt_in;
   logic [MOVE_W-1:0]      mov_ff, mov_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic                   cmd_ff, cmd_in;
   logic [CYL_W-1:0]       cyl_ff, cyl_in;
   drs_rec_type            pick_ff, pick_in;
   logic [IDX_W-1:0]       pick_idx_ff, pick_idx_in;
   logic [DIST_W-1:0]      dist_ff, dist_in;
   logic                   wrapped_ff, wrapped_in;
   logic                   last_ff, last_in;

   logic [CNT_W-1:0]       n_act;
   logic                   fcfs;
   logic                   wrap;
   logic [CYL_W-1:0]       up_term;
   logic [MOVE_W:0]        sum_wide;
   drs_write_type          wr;
   logic [IDX_W-1:0]       wr_index;
   drs_scan_type           scan;
   drs_rec_type            rec_link [SLOTS+1];
   logic [IDX_W-1:0]       idx_link [SLOTS+1];

   // Slot count in use, clamped to 1..SLOTS.
   always_comb begin
      if (slots_ff == '0) begin
         n_act = CNT_W'(1);
      end else if (32'(slots_ff) > SLOTS) begin
         n_act = CNT_W'(SLOTS);
      end else begin
         n_act = CNT_W'(slots_ff);
      end
   end

   assign fcfs       = (mode_ff != MODE_SSTF) && (mode_ff != MODE_CSCAN);
   assign scan.sstf  = (mode_ff == MODE_SSTF);
   assign scan.cscan = (mode_ff == MODE_CSCAN);
   assign scan.head  = head_ff;

   assign rec_link[0] = '0;
   assign idx_link[0] = '0;

   for (genvar g = 0; g < SLOTS; g++) begin : g_cell
      drs_cell #(
         .SLOTS      (SLOTS),
         .CELL_INDEX (g)
      ) u_cell (
         .clock    (clock),
         .reset    (reset),
         .wr       (wr),
         .wr_index (wr_index),
         .scan     (scan),
         .ptr      (ptr_work_ff),
         .rec_in   (rec_link[g]),
         .idx_in   (idx_link[g]),
         .rec_out  (rec_link[g+1]),
         .idx_out  (idx_link[g+1])
      );
   end

   assign busy      = (state_ff != ST_IDLE);
   assign csr_ready = !busy;

   always_comb begin
      state_in     = state_ff;
      mode_in      = mode_ff;
      max_in       = max_ff;
      slots_in     = slots_ff;
      head_in      = head_ff;
      fill_in      = fill_ff;
      ptr_in       = ptr_ff;
      ptr_work_in  = ptr_work_ff;
      scan_cnt_in  = scan_cnt_ff;
      mov_in       = mov_ff;
      rsp_valid_in = 1'b0;
      cmd_in       = cmd_ff;
      cyl_in       = cyl_ff;
      pick_in      = pick_ff;
      pick_idx_in  = pick_idx_ff;
      dist_in      = dist_ff;
      wrapped_in   = wrapped_ff;
      last_in      = last_ff;
      wr           = '0;
      wr_index     = '0;

      wrap     = scan.cscan && !pick_ff.up;
      up_term  = (max_ff >= head_ff) ? (max_ff - head_ff) : '0;
      sum_wide = {1'b0, mov_ff} + (MOVE_W+1)'(dist_ff);

      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd_in = req_command;
               cyl_in = req_cylinder;
               if ((fill_ff < n_act) && (req_command == CMD_REQUEST)) begin
                  wr.en    = 1'b1;
                  wr.valid = 1'b1;
                  wr.cyl   = req_cylinder;
                  wr_index = fill_ff[IDX_W-1:0];
                  fill_in  = fill_ff + CNT_W'(1);
               end else begin
                  // a drain ends the fill phase
                  if (fill_ff < n_act) begin
                     fill_in = n_act;
                  end
                  ptr_work_in = ptr_ff;
                  state_in    = ST_REDUCE;
               end
            end
         end
         ST_REDUCE: begin
            if (CNT_W'(ptr_work_ff) >= n_act) begin
               ptr_work_in = ptr_work_ff - IDX_W'(n_act);
            end else begin
               scan_cnt_in = '0;
               state_in    = ST_SCAN;
            end
         end
         ST_SCAN: begin
            scan_cnt_in = scan_cnt_ff + CNT_W'(1);
            // the record has passed every slot in use
            if (CNT_W'(scan_cnt_ff + CNT_W'(1)) == n_act) begin
               pick_in     = rec_link[n_act];
               pick_idx_in = idx_link[n_act];
               state_in    = ST_MOVE;
            end
         end
         ST_MOVE: begin
            if (!pick_ff.found) begin
               if (cmd_ff == CMD_REQUEST) begin
                  wr.en    = 1'b1;
                  wr.valid = 1'b1;
                  wr.cyl   = cyl_ff;
                  wr_index = '0;
               end
               state_in = ST_IDLE;
            end else begin
               wr.en    = 1'b1;
               wr.valid = (cmd_ff == CMD_REQUEST);
               wr.cyl   = cyl_ff;
               wr_index = pick_idx_ff;
               if (fcfs) begin
                  ptr_in = (CNT_W'(pick_idx_ff) + CNT_W'(1) == n_act) ? '0 :
                           IDX_W'(pick_idx_ff + IDX_W'(1));
               end
               if (wrap) begin
                  dist_in = DIST_W'(up_term) + DIST_W'(max_ff) + DIST_W'(pick_ff.cyl);
               end else if (pick_ff.cyl >= head_ff) begin
                  dist_in = DIST_W'(pick_ff.cyl - head_ff);
               end else begin
                  dist_in = DIST_W'(head_ff - pick_ff.cyl);
               end
               head_in    = pick_ff.cyl;
               wrapped_in = wrap;
               last_in    = (cmd_ff == CMD_DRAIN) && (pick_ff.many == 2'd1);
               state_in   = ST_SUM;
            end
         end
         ST_SUM: begin
            mov_in       = sum_wide[MOVE_W] ? '1 : sum_wide[MOVE_W-1:0];
            rsp_valid_in = 1'b1;
            state_in     = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (csr_valid && csr_ready) begin
         unique case (csr_index_type'(csr_index))
            CSR_MODE:      mode_in  = csr_data[MODE_W-1:0];
            CSR_START_POS: head_in  = csr_data[CYL_W-1:0];
            CSR_MAX_CYL:   max_in   = csr_data[CYL_W-1:0];
            CSR_SLOTS:     slots_in = csr_data[SLOTS_REG_W-1:0];
            default:       mode_in  = mode_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         mode_ff      <= MODE_FCFS;
         max_ff       <= MAX_CYL_RESET;
         slots_ff     <= SLOTS_REG_RESET;
         head_ff      <= '0;
         fill_ff      <= '0;
         ptr_ff       <= '0;
         mov_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         mode_ff      <= mode_in;
         max_ff       <= max_in;
         slots_ff     <= slots_in;
         head_ff      <= head_in;
         fill_ff      <= fill_in;
         ptr_ff       <= ptr_in;
         mov_ff       <= mov_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      ptr_work_ff <= ptr_work_in;
      scan_cnt_ff <= scan_cnt_in;
      cmd_ff      <= cmd_in;
      cyl_ff      <= cyl_in;
      pick_ff     <= pick_in;
      pick_idx_ff <= pick_idx_in;
      dist_ff     <= dist_in;
      wrapped_ff  <= wrapped_in;
      last_ff     <= last_in;
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_served_cylinder = pick_ff.cyl;
   assign rsp_total_movement  = mov_ff;
   assign rsp_wrapped         = wrapped_ff;
   assign rsp_last            = last_ff;

`ifndef SYNTHESIS
   a_rsp_after_sum: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> $past(state_ff == ST_SUM))
      else $error("response without a completed service");

   a_rsp_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |=> !rsp_valid_ff)
      else $error("response strobe longer than one cycle");

   a_wrap_cscan: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_wrapped) |-> (mode_ff == MODE_CSCAN))
      else $error("wrap reported outside circular scan");

   a_last_drain: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_last) |-> (cmd_ff == CMD_DRAIN))
      else $error("buffer emptied by a new request");

   a_scan_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN) |-> (scan_cnt_ff < n_act))
      else $error("scan ran past the slots in use");
`endif

endmodule

// ----- rtl/drs_cell.sv -----
// One buffer slot with its stage of the best-candidate search.
module drs_cell #(
   parameter int SLOTS      = drs_pkg::DEFAULT_SLOTS,
   parameter int CELL_INDEX = 0,
   localparam int IDX_W     = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
   input  logic                  clock,
   input  logic                  reset,
   input  drs_pkg::drs_write_type wr,
   input  logic [IDX_W-1:0]      wr_index,
   input  drs_pkg::drs_scan_type scan,
   input  logic [IDX_W-1:0]      ptr,
   input  drs_pkg::drs_rec_type  rec_in,
   input  logic [IDX_W-1:0]      idx_in,
   output drs_pkg::drs_rec_type  rec_out,
   output logic [IDX_W-1:0]      idx_out
);
   import drs_pkg::*;

   localparam logic [IDX_W-1:0] OWN = IDX_W'(CELL_INDEX);

   logic [CYL_W-1:0] cyl_ff;
   logic             valid_ff;
   drs_rec_type      rec_ff;
   drs_rec_type      rec_in_nx;
   logic [IDX_W-1:0] idx_ff;
   logic [IDX_W-1:0] idx_in_nx;

   logic             cand_up;
   logic [CYL_W-1:0] cand_key;
   logic             above;
   logic             take;

   always_comb begin
      above = (cyl_ff >= scan.head);
      if (scan.sstf) begin
         cand_up  = 1'b1;
         cand_key = above ? (cyl_ff - scan.head) : (scan.head - cyl_ff);
      end else if (scan.cscan) begin
         cand_up  = above;
         cand_key = above ? (cyl_ff - scan.head) : cyl_ff;
      end else begin
         // ring order: slots at or past the pointer first, lowest index within a class
         cand_up  = (OWN >= ptr);
         cand_key = '0;
      end
      take = valid_ff && (!rec_in.found || (cand_up && !rec_in.up) ||
                          ((cand_up == rec_in.up) && (cand_key < rec_in.key)));

      rec_in_nx = rec_in;
      idx_in_nx = idx_in;
      if (take) begin
         rec_in_nx.found = 1'b1;
         rec_in_nx.up    = cand_up;
         rec_in_nx.key   = cand_key;
         rec_in_nx.cyl   = cyl_ff;
         idx_in_nx       = OWN;
      end
      // saturating count of valid slots seen so far
      if (valid_ff && (rec_in.many != 2'd2)) begin
         rec_in_nx.many = rec_in.many + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (wr.en && (wr_index == OWN)) begin
         valid_ff <= wr.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (wr.en && (wr_index == OWN)) begin
         cyl_ff <= wr.cyl;
      end
      rec_ff <= rec_in_nx;
      idx_ff <= idx_in_nx;
   end

   assign rec_out = rec_ff;
   assign idx_out = idx_ff;

endmodule

// ----- tb/tb_top.sv -----
// Self-checking testbench for disk_request_scheduler_top: directed, random and long-wrap runs.
module tb_top;
   import drs_pkg::*;

   localparam logic [MODE_W-1:0] MODE_UNDEF    = 2'd3;
   localparam int                NSLOT         = DEFAULT_SLOTS;
   localparam int                SETTLE_CYCLES = NSLOT + 24;
   localparam int                MAX_REPORTS   = 40;
   localparam logic [CYL_W-1:0]  CYL_TOP       = '1;

   typedef struct {
      logic [CYL_W-1:0]  cylinder;
      logic [MOVE_W-1:0] total;
      logic              wrapped;
      logic              last;
   } service_t;

   logic                   clock;
   logic                   reset;
   logic                   start;
   logic                   busy;
   logic                   req_command;
   logic [CYL_W-1:0]       req_cylinder;
   logic                   rsp_valid;
   logic [CYL_W-1:0]       rsp_served_cylinder;
   logic [MOVE_W-1:0]      rsp_total_movement;
   logic                   rsp_wrapped;
   logic                   rsp_last;
   logic                   csr_valid;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_data;

   // Scheduler state as predicted by the testbench.
   logic [MODE_W-1:0]      sched_mode;
   logic [CYL_W-1:0]       sched_start;
   logic [CYL_W-1:0]       sched_max;
   logic [SLOTS_REG_W-1:0] sched_slots;
   logic [CYL_W-1:0]       slot_cyl [NSLOT];
   logic                   slot_vld [NSLOT];
   int                     fill_count;
   logic [CYL_W-1:0]       head_pos;
   int                     ring_ptr;
   logic [MOVE_W-1:0]      movement_sum;

   service_t               expected_services [$];
   int                     error_count;

   disk_request_scheduler_top i_dut (
      .clock               (clock),
      .reset               (reset),
      .start               (start),
      .busy                (busy),
      .req_command         (req_command),
      .req_cylinder        (req_cylinder),
      .rsp_valid           (rsp_valid),
      .rsp_served_cylinder (rsp_served_cylinder),
      .rsp_total_movement  (rsp_total_movement),
      .rsp_wrapped         (rsp_wrapped),
      .rsp_last            (rsp_last),
      .csr_valid           (csr_valid),
      .csr_ready           (csr_ready),
      .csr_index           (csr_index),
      .csr_data            (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #50000000;
      $display("** disk_request_scheduler_top: FAILED **");
      $finish;
   end

   function automatic logic [CYL_W-1:0] seek_distance(input logic [CYL_W-1:0] a,
                                                      input logic [CYL_W-1:0] b);
      return (a >= b) ? a - b : b - a;
   endfunction

   // Work out the response (if any) of one accepted request.
   task automatic predict_service(input logic cmd, input logic [CYL_W-1:0] cyl);
      int               n;
      int               i;
      int               p;
      int               idx;
      int               pick;
      logic [CYL_W-1:0] best_key;
      logic [CYL_W-1:0] served;
      logic             wrap;
      logic             any_left;
      logic [33:0]      travel;
      logic [33:0]      sum;
      service_t         svc;
      n = (sched_slots == 0) ? 1 : (sched_slots > NSLOT) ? NSLOT : int'(sched_slots);
      if (fill_count < n) begin
         if (cmd == CMD_REQUEST) begin
            slot_cyl[fill_count] = cyl;
            slot_vld[fill_count] = 1'b1;
            fill_count++;
            return;
         end
         fill_count = n;
      end
      pick = n;
      wrap = 1'b0;
      best_key = '0;
      if (sched_mode == MODE_SSTF) begin
         for (i = 0; i < n; i++) begin
            if (slot_vld[i] && (pick == n || seek_distance(slot_cyl[i], head_pos) < best_key)) begin
               pick = i;
               best_key = seek_distance(slot_cyl[i], head_pos);
            end
         end
      end else if (sched_mode == MODE_CSCAN) begin
         for (i = 0; i < n; i++) begin
            if (slot_vld[i] && slot_cyl[i] >= head_pos &&
                (pick == n || slot_cyl[i] - head_pos < best_key)) begin
               pick = i;
               best_key = slot_cyl[i] - head_pos;
            end
         end
         // nothing at or above the head: wrap to the lowest cylinder
         if (pick == n) begin
            for (i = 0; i < n; i++) begin
               if (slot_vld[i] && (pick == n || slot_cyl[i] < best_key)) begin
                  pick = i;
                  best_key = slot_cyl[i];
               end
            end
            wrap = (pick != n);
         end
      end else begin
         p = ring_ptr % n;
         for (i = 0; i < n && pick == n; i++) begin
            idx = (p + i) % n;
            if (slot_vld[idx]) begin
               pick = idx;
               ring_ptr = (idx + 1) % n;
            end
         end
      end
      if (pick == n) begin
         if (cmd == CMD_REQUEST) begin
            slot_cyl[0] = cyl;
            slot_vld[0] = 1'b1;
         end
         return;
      end
      served = slot_cyl[pick];
      if (cmd == CMD_REQUEST) slot_cyl[pick] = cyl;
      else slot_vld[pick] = 1'b0;
      if (wrap) begin
         travel = ((sched_max >= head_pos) ? 34'(sched_max - head_pos) : 34'd0)
                + 34'(sched_max) + 34'(served);
      end else begin
         travel = 34'(seek_distance(served, head_pos));
      end
      head_pos = served;
      sum = 34'(movement_sum) + travel;
      movement_sum = (sum > 34'h0_FFFF_FFFF) ? '1 : sum[MOVE_W-1:0];
      any_left = 1'b0;
      for (i = 0; i < n; i++) begin
         if (slot_vld[i]) any_left = 1'b1;
      end
      svc.cylinder = served;
      svc.total    = movement_sum;
      svc.wrapped  = wrap;
      svc.last     = !any_left;
      expected_services.push_back(svc);
   endtask

   // Raise start (or keep it up) and hold until the request is taken.
   task automatic send_request(input logic cmd, input logic [CYL_W-1:0] cyl);
      start        <= 1'b1;
      req_command  <= cmd;
      req_cylinder <= cyl;
      do @(posedge clock); while (busy);
      predict_service(cmd, cyl);
   endtask

   task automatic hold_requests(input int cycles);
      start <= 1'b0;
      repeat (cycles) @(posedge clock);
   endtask

   // Drop start, wait for every response, then let a silent service finish.
   task automatic wait_until_quiet();
      start <= 1'b0;
      while (expected_services.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_register(input csr_index_type idx, input logic [CSR_DATA_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      case (idx)
         CSR_MODE: begin
            sched_mode = data[MODE_W-1:0];
         end
         CSR_START_POS: begin
            sched_start = data[CYL_W-1:0];
            head_pos    = data[CYL_W-1:0];
         end
         CSR_MAX_CYL: begin
            sched_max = data[CYL_W-1:0];
         end
         CSR_SLOTS: begin
            sched_slots = data[SLOTS_REG_W-1:0];
         end
         default: begin
         end
      endcase
   endtask

   task automatic report_mismatch(input string field, input logic [31:0] exp_val,
                                  input logic [31:0] act_val);
      error_count++;
      if (error_count <= MAX_REPORTS)
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, exp_val, act_val);
   endtask

   always @(posedge clock) begin : response_check
      service_t svc;
      if (!reset && rsp_valid === 1'b1) begin
         if (expected_services.size() == 0) begin
            error_count++;
            if (error_count <= MAX_REPORTS)
               $display("%0t: unexpected response, expected none, actual cylinder %0d",
                        $time, rsp_served_cylinder);
         end else begin
            svc = expected_services.pop_front();
            if (rsp_served_cylinder !== svc.cylinder)
               report_mismatch("served_cylinder", svc.cylinder, rsp_served_cylinder);
            if (rsp_total_movement !== svc.total)
               report_mismatch("total_movement", svc.total, rsp_total_movement);
            if (rsp_wrapped !== svc.wrapped)
               report_mismatch("wrapped", svc.wrapped, rsp_wrapped);
            if (rsp_last !== svc.last)
               report_mismatch("last", svc.last, rsp_last);
         end
      end
   end

   // Fill, drain while filling, ring order over empty slots, empty buffer.
   task automatic test_fill_and_ring_order();
      write_register(CSR_SLOTS, 14'd3);
      write_register(CSR_MODE, CSR_DATA_W'(MODE_FCFS));
      write_register(CSR_START_POS, CYL_TOP);
      write_register(CSR_MAX_CYL, CYL_TOP);
      send_request(CMD_REQUEST, 14'd0);
      send_request(CMD_REQUEST, CYL_TOP);
      send_request(CMD_DRAIN, CYL_TOP);
      send_request(CMD_REQUEST, 14'd7);
      send_request(CMD_REQUEST, 14'd9);
      send_request(CMD_DRAIN, CYL_TOP);
      send_request(CMD_DRAIN, CYL_TOP);
      send_request(CMD_REQUEST, 14'd12);
      wait_until_quiet();
   endtask

   // Equal seek distances must go to the lowest slot.
   task automatic test_nearest_first_ties();
      write_register(CSR_SLOTS, 14'd6);
      write_register(CSR_MODE, CSR_DATA_W'(MODE_SSTF));
      write_register(CSR_START_POS, 14'd50);
      send_request(CMD_REQUEST, 14'd40);
      send_request(CMD_REQUEST, 14'd60);
      send_request(CMD_REQUEST, 14'd40);
      send_request(CMD_REQUEST, 14'd45);
      repeat (5) send_request(CMD_DRAIN, 14'd0);
      wait_until_quiet();
   endtask

   // Wrap with the head above max_cylinder, then a full-width wrap.
   task automatic test_circular_scan_wrap();
      write_register(CSR_MODE, CSR_DATA_W'(MODE_CSCAN));
      write_register(CSR_MAX_CYL, 14'd0);
      write_register(CSR_START_POS, CYL_TOP);
      send_request(CMD_REQUEST, 14'd30);
      send_request(CMD_REQUEST, CYL_TOP);
      send_request(CMD_REQUEST, 14'd20);
      wait_until_quiet();
      write_register(CSR_MAX_CYL, CYL_TOP);
      write_register(CSR_START_POS, 14'd5);
      send_request(CMD_REQUEST, 14'd2);
      send_request(CMD_REQUEST, 14'd3);
      wait_until_quiet();
   endtask

   // Undefined mode, slot count of zero below the ring pointer, stray upper data bits.
   task automatic test_slot_count_limits();
      write_register(CSR_MODE, 14'h3FF4 | 14'(MODE_UNDEF));
      write_register(CSR_SLOTS, 14'h3FE0);
      send_request(CMD_REQUEST, 14'd11);
      send_request(CMD_REQUEST, CYL_TOP);
      send_request(CMD_DRAIN, 14'h2AAA);
      wait_until_quiet();
   endtask

   task automatic test_random_traffic();
      int               phase;
      int               k;
      int               items;
      int               burst_left;
      int               count;
      bit               steady;
      logic             cmd;
      logic [CYL_W-1:0] cyl;
      for (phase = 0; phase < 11; phase++) begin
         wait_until_quiet();
         write_register(CSR_MODE, 14'({12'($urandom), 2'(phase % 4)}));
         if ($urandom_range(0, 2) != 0) begin
            case ($urandom_range(0, 3))
               0: write_register(CSR_START_POS, 14'd0);
               1: write_register(CSR_START_POS, CYL_TOP);
               default: write_register(CSR_START_POS, 14'($urandom));
            endcase
         end
         if ($urandom_range(0, 2) != 0) begin
            case ($urandom_range(0, 3))
               0: write_register(CSR_MAX_CYL, 14'd0);
               1: write_register(CSR_MAX_CYL, CYL_TOP);
               default: write_register(CSR_MAX_CYL, 14'($urandom));
            endcase
         end
         if (phase == 0 || $urandom_range(0, 3) != 0) begin
            case ($urandom_range(0, 9))
               0: count = 0;
               1: count = NSLOT;
               2: count = $urandom_range(NSLOT + 1, 31);
               default: count = $urandom_range(1, 6);
            endcase
            write_register(CSR_SLOTS, 14'({9'($urandom), 5'(count)}));
         end
         steady     = ($urandom_range(0, 3) == 0);
         burst_left = 0;
         items      = $urandom_range(30, 48);
         for (k = 0; k < items; k++) begin
            if (!steady && burst_left == 0) begin
               hold_requests($urandom_range(1, 30));
               burst_left = $urandom_range(1, 16);
            end
            if (burst_left > 0) burst_left--;
            cmd = ($urandom_range(0, 5) == 0) ? CMD_DRAIN : CMD_REQUEST;
            // small cylinders make seek ties and equal cylinders common
            case ($urandom_range(0, 9))
               0: cyl = 14'd0;
               1: cyl = CYL_TOP;
               2, 3, 4, 5: cyl = 14'($urandom_range(0, 15));
               default: cyl = 14'($urandom);
            endcase
            send_request(cmd, cyl);
         end
         // empty the buffer now and then, one extra drain on empty
         if ($urandom_range(0, 2) == 0) begin
            repeat (NSLOT + 1) send_request(CMD_DRAIN, 14'($urandom));
         end
      end
   endtask

   // One slot, circular scan down by one cylinder per request: a near-maximal
   // wrap on every service.
   task automatic test_long_wraps();
      int k;
      wait_until_quiet();
      write_register(CSR_SLOTS, 14'd1);
      write_register(CSR_MODE, CSR_DATA_W'(MODE_CSCAN));
      write_register(CSR_MAX_CYL, CYL_TOP);
      for (k = 0; k < 40; k++) begin
         send_request(CMD_REQUEST, CYL_TOP - 14'(k));
      end
   endtask

   initial begin
      sched_mode   = MODE_FCFS;
      sched_start  = '0;
      sched_max    = MAX_CYL_RESET;
      sched_slots  = SLOTS_REG_RESET;
      for (int i = 0; i < NSLOT; i++) begin
         slot_cyl[i] = '0;
         slot_vld[i] = 1'b0;
      end
      fill_count   = 0;
      head_pos     = '0;
      ring_ptr     = 0;
      movement_sum = '0;
      error_count  = 0;
      reset        <= 1'b1;
      start        <= 1'b0;
      req_command  <= CMD_REQUEST;
      req_cylinder <= '0;
      csr_valid    <= 1'b0;
      csr_index    <= CSR_MODE;
      csr_data     <= '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_fill_and_ring_order();
      test_nearest_first_ties();
      test_circular_scan_wrap();
      test_slot_count_limits();
      test_random_traffic();
      test_long_wraps();
      wait_until_quiet();
      if (error_count == 0) begin
         $display("** disk_request_scheduler_top: PASSED **");
      end else begin
         $display("** disk_request_scheduler_top: FAILED **");
      end
      $finish;
   end

endmodule
